FILE: rtl/fmtp_pkg.sv
package fmtp_pkg;

   // widths fixed by the request and result fields
   localparam int REQ_TYPE_W  = 2;
   localparam int PORT_W      = 2;
   localparam int VALUE_W     = 8;
   localparam int ELAPSED_W   = 20;
   localparam int REG_W       = 9;
   localparam int PERIOD_W    = 16;
   localparam int PRESET_W    = 8;
   localparam int TICK_W      = PRESET_W + 1;
   localparam int PROD_W      = TICK_W + PERIOD_W;
   localparam int CSR_INDEX_W = 1;

   localparam int TIME_WIDTH_DEFAULT = 64;

   // request queue between front and back, and result queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request types
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_ADVANCE = 2'd2;

   // ports
   localparam logic [PORT_W-1:0] PORT_ADDR = 2'd0;
   localparam logic [PORT_W-1:0] PORT_DATA = 2'd1;
   localparam logic [PORT_W-1:0] PORT_HIGH = 2'd2;

   // register indexes
   localparam logic [REG_W-1:0] REG_T1    = 9'h002;
   localparam logic [REG_W-1:0] REG_T2    = 9'h003;
   localparam logic [REG_W-1:0] REG_CTRL  = 9'h004;
   localparam logic [REG_W-1:0] REG_NEW   = 9'h105;
   localparam logic [REG_W-1:0] HIGH_BANK = 9'h100;

   // timer control bits
   localparam int CTRL_RESET_BIT = 7;
   localparam int CTRL_MASK1_BIT = 6;
   localparam int CTRL_MASK2_BIT = 5;
   localparam int CTRL_EN1_BIT   = 0;
   localparam int CTRL_EN2_BIT   = 1;

   // status byte
   localparam logic [VALUE_W-1:0] STATUS_ANY = 8'h80;
   localparam logic [VALUE_W-1:0] STATUS_T1  = 8'h40;
   localparam logic [VALUE_W-1:0] STATUS_T2  = 8'h20;
   localparam logic [VALUE_W-1:0] READ_HIGH  = 8'hff;

   localparam logic [TICK_W-1:0] TICK_FULL = 9'h100;

   // config registers
   localparam logic [CSR_INDEX_W-1:0] CSR_T1_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_T2_PERIOD = 1'd1;
   localparam logic [PERIOD_W-1:0] T1_PERIOD_RESET = 16'd80;
   localparam logic [PERIOD_W-1:0] T2_PERIOD_RESET = 16'd320;

   // classified operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
   localparam logic [OP_W-1:0] OP_PRESET1   = 3'd1;
   localparam logic [OP_W-1:0] OP_PRESET2   = 3'd2;
   localparam logic [OP_W-1:0] OP_CTRL      = 3'd3;
   localparam logic [OP_W-1:0] OP_FWD       = 3'd4;
   localparam logic [OP_W-1:0] OP_STATUS    = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_HIGH = 3'd6;
   localparam logic [OP_W-1:0] OP_ADVANCE   = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [REG_W-1:0]     fwd_reg;
      logic [VALUE_W-1:0]   value;
      logic [ELAPSED_W-1:0] elapsed;
   } cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_data;
      logic               fwd_valid;
      logic [REG_W-1:0]   fwd_reg;
      logic [VALUE_W-1:0] fwd_value;
      logic               opl3_mode;
   } rsp_type;

endpackage

FILE: rtl/fmtp_fifo.sv
module fmtp_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import fmtp_pkg::*;

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/fmtp_front.sv
module fmtp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [fmtp_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [fmtp_pkg::PORT_W-1:0]        req_port,
   input  logic [fmtp_pkg::VALUE_W-1:0]       req_value,
   input  logic [fmtp_pkg::ELAPSED_W-1:0]     req_elapsed_us,
   output logic                               cmd_push,
   output fmtp_pkg::cmd_type                  cmd,
   input  logic                               cmd_full
);
   import fmtp_pkg::*;

   logic [REG_W-1:0] reg_index_ff, reg_index_in;
   logic             accept;

   assign accept   = req_push && !cmd_full;
   assign req_full = cmd_full;
   assign cmd_push = accept;

   // address latch lives here so data writes are classified in request order
   always_comb begin
      cmd.op       = OP_NOP;
      cmd.fwd_reg  = reg_index_ff;
      cmd.value    = req_value;
      cmd.elapsed  = req_elapsed_us;
      reg_index_in = reg_index_ff;
      case (req_type)
         REQ_WRITE: begin
            case (req_port)
               PORT_ADDR: reg_index_in = {1'b0, req_value};
               PORT_HIGH: reg_index_in = HIGH_BANK | {1'b0, req_value};
               PORT_DATA: begin
                  case (reg_index_ff)
                     REG_T1:   cmd.op = OP_PRESET1;
                     REG_T2:   cmd.op = OP_PRESET2;
                     REG_CTRL: cmd.op = OP_CTRL;
                     default:  cmd.op = OP_FWD;
                  endcase
               end
               default: ;
            endcase
         end
         REQ_READ:    cmd.op = (req_port == PORT_HIGH) ? OP_READ_HIGH : OP_STATUS;
         REQ_ADVANCE: cmd.op = OP_ADVANCE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_index_ff <= '0;
      end else if (accept) begin
         reg_index_ff <= reg_index_in;
      end
   end

endmodule

FILE: rtl/fmtp_back.sv
module fmtp_back #(
   parameter int TIME_WIDTH = fmtp_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fmtp_pkg::PERIOD_W-1:0]   period1,
   input  logic [fmtp_pkg::PERIOD_W-1:0]   period2,
   input  logic                            cmd_empty,
   input  fmtp_pkg::cmd_type               cmd,
   output logic                            cmd_pop,
   input  logic                            rsp_full,
   output logic                            rsp_push,
   output fmtp_pkg::rsp_type               rsp
);
   import fmtp_pkg::*;

   localparam logic ST_EXEC   = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   logic                  state_ff, state_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic [TIME_WIDTH-1:0] exp1_ff, exp1_in;
   logic [TIME_WIDTH-1:0] exp2_ff, exp2_in;
   logic                  on1_ff, on1_in;
   logic                  on2_ff, on2_in;
   logic [PRESET_W-1:0]   preset1_ff, preset1_in;
   logic [PRESET_W-1:0]   preset2_ff, preset2_in;
   logic                  mode_ff, mode_in;
   logic [PROD_W-1:0]     prod1_ff, prod1_in;
   logic [PROD_W-1:0]     prod2_ff, prod2_in;
   logic [PRESET_W-1:0]   sel1, sel2;
   logic [TICK_W-1:0]     ticks1, ticks2;
   logic [TIME_WIDTH-1:0] cand1, cand2;
   logic                  needs_mul;
   logic                  finish;
   logic [VALUE_W-1:0]    status;

   // timer writes register the product first and finish from ST_FINISH, everything else finishes from ST_EXEC
   assign needs_mul = (cmd.op == OP_PRESET1) || (cmd.op == OP_PRESET2) ||
                      (cmd.op == OP_CTRL);
   assign finish    = !cmd_empty && !rsp_full &&
                      ((state_ff == ST_FINISH) || !needs_mul);
   assign cmd_pop   = finish;
   assign rsp_push  = finish;

   // a preset write uses the new preset for its own expiry
   assign sel1   = (cmd.op == OP_PRESET1) ? cmd.value : preset1_ff;
   assign sel2   = (cmd.op == OP_PRESET2) ? cmd.value : preset2_ff;
   assign ticks1 = TICK_FULL - {1'b0, sel1};
   assign ticks2 = TICK_FULL - {1'b0, sel2};
   assign prod1_in = PROD_W'(ticks1) * PROD_W'(period1);
   assign prod2_in = PROD_W'(ticks2) * PROD_W'(period2);

   assign cand1 = time_ff + TIME_WIDTH'(prod1_ff);
   assign cand2 = time_ff + TIME_WIDTH'(prod2_ff);

   always_comb begin
      status = '0;
      if (on1_ff && (time_ff > exp1_ff)) begin
         status = status | STATUS_ANY | STATUS_T1;
      end
      if (on2_ff && (time_ff > exp2_ff)) begin
         status = status | STATUS_ANY | STATUS_T2;
      end
   end

   always_comb begin
      state_in   = state_ff;
      time_in    = time_ff;
      exp1_in    = exp1_ff;
      exp2_in    = exp2_ff;
      on1_in     = on1_ff;
      on2_in     = on2_ff;
      preset1_in = preset1_ff;
      preset2_in = preset2_ff;
      mode_in    = mode_ff;
      rsp        = '0;

      if (state_ff == ST_EXEC && !cmd_empty && needs_mul) begin
         state_in = ST_FINISH;
      end
      if (finish) begin
         state_in = ST_EXEC;
         case (cmd.op)
            OP_PRESET1: begin
               preset1_in = cmd.value;
               if (on1_ff) begin
                  exp1_in = cand1;
               end
            end
            OP_PRESET2: begin
               preset2_in = cmd.value;
               if (on2_ff) begin
                  exp2_in = cand2;
               end
            end
            OP_CTRL: begin
               if (cmd.value[CTRL_RESET_BIT]) begin
                  on1_in = 1'b0;
                  on2_in = 1'b0;
               end else begin
                  if (!cmd.value[CTRL_MASK1_BIT]) begin
                     on1_in = cmd.value[CTRL_EN1_BIT];
                     if (cmd.value[CTRL_EN1_BIT]) begin
                        exp1_in = cand1;
                     end
                  end
                  if (!cmd.value[CTRL_MASK2_BIT]) begin
                     on2_in = cmd.value[CTRL_EN2_BIT];
                     if (cmd.value[CTRL_EN2_BIT]) begin
                        exp2_in = cand2;
                     end
                  end
               end
            end
            OP_FWD: begin
               if (cmd.fwd_reg == REG_NEW) begin
                  mode_in = cmd.value[0];
               end
               rsp.fwd_valid = 1'b1;
               rsp.fwd_reg   = cmd.fwd_reg;
               rsp.fwd_value = cmd.value;
            end
            OP_STATUS:    rsp.read_data = status;
            OP_READ_HIGH: rsp.read_data = READ_HIGH;
            OP_ADVANCE:   time_in = time_ff + TIME_WIDTH'(cmd.elapsed);
            default: ;
         endcase
      end
      rsp.opl3_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_EXEC;
         time_ff    <= '0;
         exp1_ff    <= '0;
         exp2_ff    <= '0;
         on1_ff     <= 1'b0;
         on2_ff     <= 1'b0;
         preset1_ff <= '0;
         preset2_ff <= '0;
         mode_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         time_ff    <= time_in;
         exp1_ff    <= exp1_in;
         exp2_ff    <= exp2_in;
         on1_ff     <= on1_in;
         on2_ff     <= on2_in;
         preset1_ff <= preset1_in;
         preset2_ff <= preset2_in;
         mode_ff    <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
      end
   end

endmodule

FILE: rtl/fm_chip_timer_port_core.sv
// channel   | ports                                   | accepted when
// ----------+-----------------------------------------+--------------------------
// request   | req_push, req_full, req_type/port/...   | req_push && !req_full
// response  | rsp_empty, rsp_pop, rsp_read_data/...   | rsp_pop && !rsp_empty
// csr       | csr_we, csr_index, csr_wdata            | csr_we
//
// one response per request; requests enter a two-entry queue so a new one is
// taken every cycle while the queue has room, even with a response waiting
// address writes, reads, time advances and forwarded writes finish from ST_EXEC;
// preset and timer control writes register a 9x16 multiply for the tick count,
// then finish from ST_FINISH with the time-wide add of the expiry
// reset is synchronous and clears time, timers, the address latch and queues
// a full response queue stalls the back end, which in turn fills the request
// queue and raises req_full
module fm_chip_timer_port_core #(
   parameter int TIME_WIDTH = fmtp_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [fmtp_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic [fmtp_pkg::PORT_W-1:0]       req_port,
   input  logic [fmtp_pkg::VALUE_W-1:0]      req_value,
   input  logic [fmtp_pkg::ELAPSED_W-1:0]    req_elapsed_us,
   // response side
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [fmtp_pkg::VALUE_W-1:0]      rsp_read_data,
   output logic                              rsp_fwd_valid,
   output logic [fmtp_pkg::REG_W-1:0]        rsp_fwd_reg,
   output logic [fmtp_pkg::VALUE_W-1:0]      rsp_fwd_value,
   output logic                              rsp_opl3_mode,
   // config writes
   input  logic                              csr_we,
   input  logic [fmtp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fmtp_pkg::PERIOD_W-1:0]     csr_wdata
);
   import fmtp_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   // tick periods in microseconds
   logic [PERIOD_W-1:0] period1_ff;
   logic [PERIOD_W-1:0] period2_ff;

   logic       cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type    cmd_in, cmd_out;
   logic [CMD_W-1:0] cmd_out_bits;
   logic       rsp_push, rsp_full;
   rsp_type    rsp_in, rsp_out;
   logic [RSP_W-1:0] rsp_out_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         period1_ff <= T1_PERIOD_RESET;
         period2_ff <= T2_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_T1_PERIOD: period1_ff <= csr_wdata;
            CSR_T2_PERIOD: period2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: address latch and request classification
   fmtp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_port       (req_port),
      .req_value      (req_value),
      .req_elapsed_us (req_elapsed_us),
      .cmd_push       (cmd_push),
      .cmd            (cmd_in),
      .cmd_full       (cmd_full)
   );

   // decoupling queue between front and back
   fmtp_fifo #(
      .WIDTH (CMD_W)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_bits),
      .empty     (cmd_empty)
   );

   assign cmd_out = cmd_type'(cmd_out_bits);

   // back: time base, timers, status and forwarding
   fmtp_back #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .period1   (period1_ff),
      .period2   (period2_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   // response queue keeps the back end running while a response waits
   fmtp_fifo #(
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_bits),
      .empty     (rsp_empty)
   );

   assign rsp_out       = rsp_type'(rsp_out_bits);
   assign rsp_read_data = rsp_out.read_data;
   assign rsp_fwd_valid = rsp_out.fwd_valid;
   assign rsp_fwd_reg   = rsp_out.fwd_reg;
   assign rsp_fwd_value = rsp_out.fwd_value;
   assign rsp_opl3_mode = rsp_out.opl3_mode;

endmodule
